// ----- src/thcr_pkg.sv -----
// Shared types, constants and digit helpers for the twelve-hour clock with trim and ramp.
package thcr_pkg;

	typedef enum logic {
		CMD_SECOND = 1'b0,
		CMD_RAMP   = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		REG_SWING_LOW  = 2'd0,
		REG_SWING_HIGH = 2'd1,
		REG_RAMP_DELAY = 2'd2
	} reg_idx_t;

	localparam int unsigned DUTY_W  = 10;
	localparam int unsigned DELAY_W = 16;
	localparam int unsigned CFG_W   = 16;
	localparam int unsigned IDX_W   = 2;

	localparam logic [DUTY_W-1:0]  SWING_LOW_RST  = 10'd0;
	localparam logic [DUTY_W-1:0]  SWING_HIGH_RST = 10'd1023;
	localparam logic [DELAY_W-1:0] RAMP_DELAY_RST = 16'd64;

	localparam logic [3:0] HOUR_RST   = 4'd10;
	localparam logic [5:0] MINUTE_RST = 6'd16;
	localparam logic [3:0] HOUR_WRAP  = 4'd13;
	localparam logic [5:0] SIXTY      = 6'd60;
	localparam logic [5:0] TRIM_MIN   = 6'd32;
	localparam logic [5:0] TRIM_SEC   = 6'd30;
	localparam logic [4:0] HOLDOFF    = 5'd30;
	localparam logic [9:0] MID_SAMPLE = 10'h200;

	typedef struct packed {
		logic [DUTY_W-1:0]  swing_low;
		logic [DUTY_W-1:0]  swing_high;
		logic [DELAY_W-1:0] ramp_delay;
	} cfg_t;

	typedef struct packed {
		logic       cmd;
		logic [9:0] trim_sample;
	} item_t;

	typedef struct packed {
		logic              hour_tens;
		logic [3:0]        hour_ones;
		logic [2:0]        minute_tens;
		logic [3:0]        minute_ones;
		logic [8:0]        seconds_duty;
		logic [DUTY_W-1:0] pendulum_duty;
		logic              duty_stepped;
		logic              display_refresh;
		logic              trim_applied;
	} result_t;

	// {tens, ones} of an hour count 0..15
	function automatic logic [4:0] hour_digits(input logic [3:0] h);
		logic       t;
		logic [3:0] o;
		t = (h >= 4'd10);
		o = t ? (h - 4'd10) : h;
		return {t, o};
	endfunction

	// {tens, ones} of a minute count 0..63
	function automatic logic [6:0] minute_digits(input logic [5:0] m);
		logic [2:0] t;
		logic [5:0] o;
		if (m >= 6'd60) begin
			t = 3'd6; o = m - 6'd60;
		end else if (m >= 6'd50) begin
			t = 3'd5; o = m - 6'd50;
		end else if (m >= 6'd40) begin
			t = 3'd4; o = m - 6'd40;
		end else if (m >= 6'd30) begin
			t = 3'd3; o = m - 6'd30;
		end else if (m >= 6'd20) begin
			t = 3'd2; o = m - 6'd20;
		end else if (m >= 6'd10) begin
			t = 3'd1; o = m - 6'd10;
		end else begin
			t = 3'd0; o = m;
		end
		return {t, o[3:0]};
	endfunction

endpackage

// ----- src/thcr_ifs.sv -----
// Request and result channel interfaces.
interface thcr_req_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [9:0] trim_sample;
	modport source(output valid, cmd, trim_sample, input ready);
	modport sink(input valid, cmd, trim_sample, output ready);
endinterface

interface thcr_rsp_if;
	logic       valid;
	logic       ready;
	logic       hour_tens;
	logic [3:0] hour_ones;
	logic [2:0] minute_tens;
	logic [3:0] minute_ones;
	logic [8:0] seconds_duty;
	logic [9:0] pendulum_duty;
	logic       duty_stepped;
	logic       display_refresh;
	logic       trim_applied;
	modport source(output valid, hour_tens, hour_ones, minute_tens, minute_ones,
		seconds_duty, pendulum_duty, duty_stepped, display_refresh, trim_applied,
		input ready);
	modport sink(input valid, hour_tens, hour_ones, minute_tens, minute_ones,
		seconds_duty, pendulum_duty, duty_stepped, display_refresh, trim_applied,
		output ready);
endinterface

// ----- src/thcr_cfg.sv -----
// Configuration registers: swing duty levels and ramp delay.
module thcr_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [thcr_pkg::IDX_W-1:0]     cfg_index,
	input  logic [thcr_pkg::CFG_W-1:0]     cfg_data,
	output thcr_pkg::cfg_t                 cfg
);
	thcr_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.swing_low  <= thcr_pkg::SWING_LOW_RST;
			cfg_q.swing_high <= thcr_pkg::SWING_HIGH_RST;
			cfg_q.ramp_delay <= thcr_pkg::RAMP_DELAY_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				thcr_pkg::REG_SWING_LOW:  cfg_q.swing_low  <= cfg_data[thcr_pkg::DUTY_W-1:0];
				thcr_pkg::REG_SWING_HIGH: cfg_q.swing_high <= cfg_data[thcr_pkg::DUTY_W-1:0];
				thcr_pkg::REG_RAMP_DELAY: cfg_q.ramp_delay <= cfg_data[thcr_pkg::DELAY_W-1:0];
				default: ; // drop writes past the last register
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

// ----- src/thcr_core.sv -----
// Clock state, drift trim and pendulum ramp: next-state and result logic.
module thcr_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  thcr_pkg::item_t   item,
	input  thcr_pkg::cfg_t    cfg,
	output thcr_pkg::result_t result
);
	logic [3:0]  hour_count_q, hour_count_n;
	logic [5:0]  minute_count_q, minute_count_n;
	logic [5:0]  second_count_q, second_count_n;
	logic [7:0]  trim_remainder_q, trim_remainder_n;
	logic [4:0]  trim_holdoff_q, trim_holdoff_n;
	logic [9:0]  pendulum_target_q, pendulum_target_n;
	logic [9:0]  pendulum_level_q, pendulum_level_n;
	logic [15:0] ramp_countdown_q, ramp_countdown_n;
	logic        settle_pending_q, settle_pending_n;

	logic        forward;
	logic [10:0] trim_dist;
	logic [8:0]  rem_sum;
	logic [1:0]  trim_secs;
	logic [15:0] cd_dec;
	logic [5:0]  sec_inc, min_inc;
	logic [3:0]  hour_inc;
	logic        stepped, refresh, trimmed;
	logic [4:0]  hdig;
	logic [6:0]  mdig;

	always_comb begin
		hour_count_n      = hour_count_q;
		minute_count_n    = minute_count_q;
		second_count_n    = second_count_q;
		trim_remainder_n  = trim_remainder_q;
		trim_holdoff_n    = trim_holdoff_q;
		pendulum_target_n = pendulum_target_q;
		pendulum_level_n  = pendulum_level_q;
		ramp_countdown_n  = ramp_countdown_q;
		settle_pending_n  = settle_pending_q;
		stepped = 1'b0;
		refresh = 1'b0;
		trimmed = 1'b0;

		forward   = item.trim_sample[9];
		trim_dist = forward ? {2'b00, item.trim_sample[8:0]}
		                    : ({1'b0, thcr_pkg::MID_SAMPLE} - {1'b0, item.trim_sample});
		rem_sum   = {1'b0, trim_remainder_q} + {1'b0, trim_dist[7:0]};
		trim_secs = trim_dist[9:8] + {1'b0, rem_sum[8]};

		sec_inc  = second_count_q + 6'd1;
		min_inc  = minute_count_q + 6'd1;
		hour_inc = hour_count_q + 4'd1;
		cd_dec   = ramp_countdown_q - 16'd1;

		if (item.cmd == thcr_pkg::CMD_SECOND) begin
			pendulum_target_n = (pendulum_target_q == cfg.swing_low) ? cfg.swing_high
			                                                         : cfg.swing_low;
			second_count_n = sec_inc;
			if (sec_inc == thcr_pkg::SIXTY) begin
				second_count_n = 6'd0;
				minute_count_n = min_inc;
				if (min_inc == thcr_pkg::SIXTY) begin
					minute_count_n = 6'd0;
					hour_count_n   = (hour_inc == thcr_pkg::HOUR_WRAP) ? 4'd1 : hour_inc;
				end
			end
			if (trim_holdoff_q == 5'd0) begin
				if (minute_count_n == thcr_pkg::TRIM_MIN &&
						second_count_n == thcr_pkg::TRIM_SEC) begin
					trim_remainder_n = rem_sum[7:0];
					second_count_n   = forward ? (second_count_n + {4'd0, trim_secs})
					                           : (second_count_n - {4'd0, trim_secs});
					trim_holdoff_n   = thcr_pkg::HOLDOFF;
					trimmed          = 1'b1;
				end
			end else begin
				trim_holdoff_n = trim_holdoff_q - 5'd1;
			end
			refresh = 1'b1;
		end else begin
			ramp_countdown_n = cd_dec;
			if (cd_dec == 16'd0) begin
				ramp_countdown_n = cfg.ramp_delay;
				if (pendulum_level_q == pendulum_target_q) begin
					if (settle_pending_q) begin
						settle_pending_n = 1'b0;
						refresh          = 1'b1;
					end
				end else begin
					settle_pending_n = 1'b1;
					pendulum_level_n = (pendulum_level_q < pendulum_target_q)
					                   ? pendulum_level_q + 10'd1 : pendulum_level_q - 10'd1;
					stepped = 1'b1;
				end
			end
		end

		hdig = thcr_pkg::hour_digits(hour_count_n);
		mdig = thcr_pkg::minute_digits(minute_count_n);
		result.hour_tens       = hdig[4];
		result.hour_ones       = hdig[3:0];
		result.minute_tens     = mdig[6:4];
		result.minute_ones     = mdig[3:0];
		// seconds times six as 4s + 2s
		result.seconds_duty    = {1'b0, second_count_n, 2'b00} + {2'b00, second_count_n, 1'b0};
		result.pendulum_duty   = pendulum_level_n;
		result.duty_stepped    = stepped;
		result.display_refresh = refresh;
		result.trim_applied    = trimmed;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hour_count_q      <= thcr_pkg::HOUR_RST;
			minute_count_q    <= thcr_pkg::MINUTE_RST;
			second_count_q    <= 6'd0;
			trim_remainder_q  <= 8'd0;
			trim_holdoff_q    <= 5'd0;
			pendulum_target_q <= 10'd0;
			pendulum_level_q  <= 10'd0;
			ramp_countdown_q  <= thcr_pkg::RAMP_DELAY_RST;
			settle_pending_q  <= 1'b0;
		end else if (advance) begin
			hour_count_q      <= hour_count_n;
			minute_count_q    <= minute_count_n;
			second_count_q    <= second_count_n;
			trim_remainder_q  <= trim_remainder_n;
			trim_holdoff_q    <= trim_holdoff_n;
			pendulum_target_q <= pendulum_target_n;
			pendulum_level_q  <= pendulum_level_n;
			ramp_countdown_q  <= ramp_countdown_n;
			settle_pending_q  <= settle_pending_n;
		end
	end

	a_trim_starts_holdoff: assert property (@(posedge clk) disable iff (!arst_n)
		advance && result.trim_applied |=> trim_holdoff_q == thcr_pkg::HOLDOFF)
		else $error("trim did not start the hold-off");

	a_step_sets_settle: assert property (@(posedge clk) disable iff (!arst_n)
		advance && result.duty_stepped |=> settle_pending_q)
		else $error("duty step did not mark settle pending");

	a_time_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		hour_count_q >= 4'd1 && hour_count_q <= 4'd12 &&
		minute_count_q < thcr_pkg::SIXTY && second_count_q < thcr_pkg::SIXTY)
		else $error("time counters out of range");

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(second_count_q) && $stable(pendulum_level_q) &&
		$stable(ramp_countdown_q))
		else $error("state changed without a request");
endmodule

// ----- src/twelve_hour_clock_trim_ramp.sv -----
// Twelve-hour clock with drift trim and slewed pendulum duty: top level.
//
// Requests arrive on req (valid/ready): cmd 0 is a one-second tick, cmd 1 a
// ramp tick; trim_sample is the trimmer reading used at minute 32 second 30.
// Every request gives exactly one result on rsp (valid/ready): the hour and
// minute digits, seconds meter duty, pendulum duty and three event flags.
// Configuration (low and high swing levels, ramp delay) is written through
// cfg_we/cfg_index/cfg_data while no request is in flight.
//
// A request is captured in an input register; when the result register is free
// or rsp takes its result, the clock state is updated and the result register
// is loaded with the new result. One request is taken every cycle while rsp is
// ready; the single state update per cycle sets that rate.
// When rsp stalls, the result register holds and the input register keeps
// one more request, after which req.ready drops until rsp drains.
// Reset loads time 10:16:00, duty levels 0 and 1023, ramp delay 64, and
// empties both registers.
module twelve_hour_clock_trim_ramp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [thcr_pkg::IDX_W-1:0] cfg_index,
	input  logic [thcr_pkg::CFG_W-1:0] cfg_data,
	thcr_req_if.sink                   req,
	thcr_rsp_if.source                 rsp
);
	thcr_pkg::cfg_t    cfg;
	thcr_pkg::item_t   item_s1;
	thcr_pkg::result_t result;
	thcr_pkg::result_t res_s2;
	logic              valid_s1;
	logic              valid_s2;
	logic              advance;

	thcr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// move the captured request into the result register
	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.cmd         <= req.cmd;
			item_s1.trim_sample <= req.trim_sample;
		end
	end

	thcr_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= result;
		end
	end

	assign rsp.valid           = valid_s2;
	assign rsp.hour_tens       = res_s2.hour_tens;
	assign rsp.hour_ones       = res_s2.hour_ones;
	assign rsp.minute_tens     = res_s2.minute_tens;
	assign rsp.minute_ones     = res_s2.minute_ones;
	assign rsp.seconds_duty    = res_s2.seconds_duty;
	assign rsp.pendulum_duty   = res_s2.pendulum_duty;
	assign rsp.duty_stepped    = res_s2.duty_stepped;
	assign rsp.display_refresh = res_s2.display_refresh;
	assign rsp.trim_applied    = res_s2.trim_applied;
endmodule
